FILE: design/fcl_pkg.sv
// Shared constants, operation codes and register indexes of the fully connected layer engine.
package fcl_pkg;

    // Default sizes of the layer.
    localparam int DEF_IN_MAX     = 64;
    localparam int DEF_OUT_MAX    = 64;
    localparam int DEF_BATCH_MAX  = 16;
    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 12;

    // Fixed field and arithmetic widths.
    localparam int GRAD_W     = 24;
    localparam int RATE_W     = 16;
    localparam int IDX_W      = 6;
    localparam int SMP_W      = 4;
    localparam int OP_W       = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Operation codes carried on the input tuser.
    localparam logic [OP_W-1:0] OP_LOAD_W = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 3'd1;
    localparam logic [OP_W-1:0] OP_FWD    = 3'd2;
    localparam logic [OP_W-1:0] OP_BWD    = 3'd3;
    localparam logic [OP_W-1:0] OP_UPD    = 3'd4;
    localparam logic [OP_W-1:0] OP_CLR    = 3'd5;
    localparam logic [OP_W-1:0] OP_RD_W   = 3'd6;
    localparam logic [OP_W-1:0] OP_RD_B   = 3'd7;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_FWD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DX   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RD_W = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RD_B = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INPUTS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUTS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE    = 2'd3;

    // Configuration reset values.
    localparam logic [6:0]        RST_INPUTS  = 7'd64;
    localparam logic [6:0]        RST_OUTPUTS = 7'd64;
    localparam logic [4:0]        RST_BATCH   = 5'd1;
    localparam logic [RATE_W-1:0] RST_RATE    = 16'd655;

endpackage

FILE: design/fully_connected_layer_train_core.sv
// Fully connected layer engine: forward, backward, gradient update, memory-centered.
//
// Input stream (s_): one beat is one command; tuser holds the opcode (load weight,
// load bias, forward element, backward element, update, clear gradients, read weight,
// read bias). Output stream (m_): forward outputs, input gradients and read answers.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata), written idle.
// Loads and clears are done as the beat is accepted. A forward element runs one
// multiply-accumulate per output in use over the weight memory port; the last element
// of a sample then emits one result per output. A backward element sweeps all IN_MAX
// columns of its weight and gradient rows; the last row of a column emits the input
// gradients. Update walks outputs * (inputs + 1) entries, one per cycle. A read answers
// with a single result beat.
// The next command is taken while the last result still waits in the output register;
// a stalled receiver holds emission, which resumes where it stopped.
// Reset clears configuration, the bias and gradient row valid bits (biases and
// gradients then read as zero) and the handshake state; no clearing pass is needed.
module fully_connected_layer_train_core
    import fcl_pkg::*;
#(
    parameter int IN_MAX     = DEF_IN_MAX,
    parameter int OUT_MAX    = DEF_OUT_MAX,
    parameter int BATCH_MAX  = DEF_BATCH_MAX,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int S_TDATA_W = ((2 * IDX_W + SMP_W + DATA_WIDTH + 7) / 8) * 8,
    localparam int M_TDATA_W = ((IDX_W + SMP_W + DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [OP_W-1:0]       s_tuser,   // opcode
    input  logic [S_TDATA_W-1:0]  s_tdata,   // out_index, in_index, sample, value
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [KIND_W:0]       m_tuser,   // kind, saturated
    output logic                  m_tlast,
    output logic [M_TDATA_W-1:0]  m_tdata    // index, result_sample, result_value
);

    localparam int DW      = DATA_WIDTH;
    localparam int MAXD    = (IN_MAX > OUT_MAX) ? IN_MAX : OUT_MAX;
    localparam int CNT_W   = $clog2(MAXD + 2);
    localparam int IA_W    = (IN_MAX > 1) ? $clog2(IN_MAX) : 1;
    localparam int OA_W    = (OUT_MAX > 1) ? $clog2(OUT_MAX) : 1;
    localparam int W_DEPTH = OUT_MAX * IN_MAX;
    localparam int W_AW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
    localparam int X_DEPTH = BATCH_MAX * IN_MAX;
    localparam int X_AW    = (X_DEPTH > 1) ? $clog2(X_DEPTH) : 1;
    localparam int NB_W    = $clog2(BATCH_MAX + 1);
    localparam int ACC_W   = 2 * DW + 8;
    localparam int MB_AW   = (DW > RATE_W + 1) ? DW : RATE_W + 1;
    localparam int MB_BW   = (DW > GRAD_W) ? DW : GRAD_W;
    localparam int MB_PW   = MB_AW + MB_BW;
    localparam int WIDE_W  = ((ACC_W > MB_PW) ? ACC_W : MB_PW) + 2;

    localparam logic signed [WIDE_W-1:0] HALF_F = WIDE_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [WIDE_W-1:0] HALF_R = WIDE_W'(1) << (RATE_W - 1);
    localparam logic signed [WIDE_W-1:0] G_MAX  = (WIDE_W'(1) << (GRAD_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] G_MIN  = ~G_MAX;
    localparam logic signed [WIDE_W-1:0] D_MAX  = (WIDE_W'(1) << (DW - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] D_MIN  = ~D_MAX;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_FWD     = 4'd1;
    localparam logic [3:0] ST_BWD     = 4'd2;
    localparam logic [3:0] ST_UPD     = 4'd3;
    localparam logic [3:0] ST_DRAIN   = 4'd4;
    localparam logic [3:0] ST_EMIT_RD = 4'd5;
    localparam logic [3:0] ST_EMIT_WR = 4'd6;
    localparam logic [3:0] ST_RD      = 4'd7;
    localparam logic [3:0] ST_RD_OUT  = 4'd8;

    function automatic logic [W_AW-1:0] waddr(input int unsigned row, input int unsigned col);
        return W_AW'(row * IN_MAX + col);
    endfunction

    function automatic logic [X_AW-1:0] xaddr(input int unsigned smp, input int unsigned col);
        return X_AW'(smp * IN_MAX + col);
    endfunction

    // Configuration registers.
    logic [6:0]        nin_cfg_reg;
    logic [6:0]        nout_cfg_reg;
    logic [4:0]        batch_cfg_reg;
    logic [RATE_W-1:0] rate_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nin_cfg_reg   <= RST_INPUTS;
            nout_cfg_reg  <= RST_OUTPUTS;
            batch_cfg_reg <= RST_BATCH;
            rate_reg      <= RST_RATE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_INPUTS:  nin_cfg_reg   <= cfg_wdata[6:0];
                CFG_OUTPUTS: nout_cfg_reg  <= cfg_wdata[6:0];
                CFG_BATCH:   batch_cfg_reg <= cfg_wdata[4:0];
                CFG_RATE:    rate_reg      <= cfg_wdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // Sizes in use, clamped to the built range.
    logic [CNT_W-1:0] nin;
    logic [CNT_W-1:0] nout;
    logic [NB_W-1:0]  nb;

    assign nin  = (nin_cfg_reg == 7'd0) ? CNT_W'(1) :
                  (32'(nin_cfg_reg) > IN_MAX) ? CNT_W'(IN_MAX) : CNT_W'(nin_cfg_reg);
    assign nout = (nout_cfg_reg == 7'd0) ? CNT_W'(1) :
                  (32'(nout_cfg_reg) > OUT_MAX) ? CNT_W'(OUT_MAX) : CNT_W'(nout_cfg_reg);
    assign nb   = (batch_cfg_reg == 5'd0) ? NB_W'(1) :
                  (32'(batch_cfg_reg) > BATCH_MAX) ? NB_W'(BATCH_MAX) : NB_W'(batch_cfg_reg);

    // Input beat fields.
    logic [IDX_W-1:0]     in_oi;
    logic [IDX_W-1:0]     in_ii;
    logic [SMP_W-1:0]     in_smp;
    logic signed [DW-1:0] in_val;

    assign in_oi  = s_tdata[IDX_W-1:0];
    assign in_ii  = s_tdata[2*IDX_W-1:IDX_W];
    assign in_smp = s_tdata[2*IDX_W+SMP_W-1:2*IDX_W];
    assign in_val = $signed(s_tdata[2*IDX_W+SMP_W+DW-1:2*IDX_W+SMP_W]);

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic             accept;
    logic             issue;
    logic             in_w_ok, in_b_ok, in_fwd_ok, in_bwd_ok;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign in_w_ok   = (32'(in_oi) < OUT_MAX) && (32'(in_ii) < IN_MAX);
    assign in_b_ok   = (32'(in_oi) < OUT_MAX);
    assign in_fwd_ok = (32'(in_ii) < 32'(nin)) && (32'(in_smp) < 32'(nb));
    assign in_bwd_ok = (32'(in_oi) < 32'(nout)) && (32'(in_smp) < 32'(nb));

    // Latched command.
    logic [OP_W-1:0]      op_reg;
    logic [IDX_W-1:0]     oi_reg;
    logic [IDX_W-1:0]     ii_reg;
    logic [SMP_W-1:0]     smp_reg;
    logic signed [DW-1:0] val_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= s_tuser;
            oi_reg  <= in_oi;
            ii_reg  <= in_ii;
            smp_reg <= in_smp;
            val_reg <= in_val;
        end
    end

    logic rd_w_ok, rd_b_ok;
    assign rd_w_ok = (32'(oi_reg) < OUT_MAX) && (32'(ii_reg) < IN_MAX);
    assign rd_b_ok = (32'(oi_reg) < OUT_MAX);

    // Pipeline control.
    logic             s1_vld_reg, s2_vld_reg;
    logic [CNT_W-1:0] s1_j_reg, s2_j_reg;
    logic [CNT_W-1:0] s1_o_reg, s2_o_reg;
    logic             s1_bias_reg, s2_bias_reg;
    logic             m_vld_reg;
    logic             out_free;
    logic [CNT_W-1:0] emit_cnt;
    logic [CNT_W-1:0] upd_col;

    assign out_free = !m_vld_reg || m_tready;
    assign emit_cnt = (op_reg == OP_FWD) ? nout : nin;
    assign upd_col  = (j_reg == nin) ? '0 : j_reg;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        issue      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    j_next = '0;
                    k_next = '0;
                    case (s_tuser)
                        OP_FWD:  if (in_fwd_ok) state_next = ST_FWD;
                        OP_BWD:  if (in_bwd_ok) state_next = ST_BWD;
                        OP_UPD:  state_next = ST_UPD;
                        OP_RD_W: state_next = ST_RD;
                        OP_RD_B: state_next = ST_RD;
                        default: ;
                    endcase
                end
            end
            ST_FWD: begin
                issue = 1'b1;
                if (j_reg == nout - CNT_W'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_BWD: begin
                issue = 1'b1;
                if (32'(j_reg) == IN_MAX - 1) begin
                    state_next = ST_DRAIN;
                end else begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_UPD: begin
                issue = 1'b1;
                if (j_reg == nin) begin
                    j_next = '0;
                    if (k_reg == nout - CNT_W'(1)) begin
                        state_next = ST_DRAIN;
                    end else begin
                        k_next = k_reg + CNT_W'(1);
                    end
                end else begin
                    j_next = j_reg + CNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!s1_vld_reg && !s2_vld_reg) begin
                    j_next = '0;
                    if ((op_reg == OP_FWD && 32'(ii_reg) == 32'(nin) - 1) ||
                        (op_reg == OP_BWD && 32'(oi_reg) == 32'(nout) - 1)) begin
                        state_next = ST_EMIT_RD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT_RD: begin
                if (out_free) state_next = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (j_reg == emit_cnt - CNT_W'(1)) begin
                    state_next = ST_IDLE;
                end else begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            ST_RD: begin
                if (out_free) state_next = ST_RD_OUT;
            end
            ST_RD_OUT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Memory read addresses.
    logic [W_AW-1:0] w_ra, wg_ra;
    logic [OA_W-1:0] b_ra, bg_ra, facc_ra;
    logic [X_AW-1:0] x_ra;
    logic [IA_W-1:0] bacc_ra;

    always_comb begin
        case (state_reg)
            ST_FWD:  w_ra = waddr(32'(j_reg), 32'(ii_reg));
            ST_BWD:  w_ra = waddr(32'(oi_reg), 32'(j_reg));
            ST_UPD:  w_ra = waddr(32'(k_reg), 32'(upd_col));
            default: w_ra = rd_w_ok ? waddr(32'(oi_reg), 32'(ii_reg)) : '0;
        endcase
        wg_ra   = (state_reg == ST_BWD) ? waddr(32'(oi_reg), 32'(j_reg))
                                        : waddr(32'(k_reg), 32'(upd_col));
        case (state_reg)
            ST_FWD:  b_ra = OA_W'(j_reg);
            ST_UPD:  b_ra = OA_W'(k_reg);
            default: b_ra = OA_W'(oi_reg);
        endcase
        bg_ra   = (state_reg == ST_BWD) ? OA_W'(oi_reg) : OA_W'(k_reg);
        x_ra    = xaddr(32'(smp_reg), 32'(j_reg));
        facc_ra = OA_W'(j_reg);
        bacc_ra = IA_W'(j_reg);
    end

    // Stage 2 results, used by the write ports.
    logic [ACC_W-1:0]     acc_new;
    logic [GRAD_W-1:0]    grad_new;
    logic [GRAD_W-1:0]    bgrad_new;
    logic [DW-1:0]        upd_new;
    logic [GRAD_W-1:0]    grad_old_reg;
    logic [GRAD_W-1:0]    bgrad_old_reg;
    logic                 s2_in_use;

    assign s2_in_use = (s2_j_reg < nin);

    // Memory write ports.
    logic            w_we, b_we, wg_we, bg_we, x_we, facc_we, bacc_we;
    logic [W_AW-1:0] w_wa, wg_wa;
    logic [OA_W-1:0] b_wa, bg_wa, facc_wa;
    logic [X_AW-1:0] x_wa;
    logic [IA_W-1:0] bacc_wa;
    logic [DW-1:0]   w_wd, b_wd;

    always_comb begin
        w_we = 1'b0;
        w_wa = waddr(32'(s2_o_reg), 32'(s2_j_reg));
        w_wd = upd_new;
        if (accept && s_tuser == OP_LOAD_W && in_w_ok) begin
            w_we = 1'b1;
            w_wa = waddr(32'(in_oi), 32'(in_ii));
            w_wd = in_val;
        end else if (s2_vld_reg && op_reg == OP_UPD && !s2_bias_reg) begin
            w_we = 1'b1;
        end
        b_we = 1'b0;
        b_wa = OA_W'(s2_o_reg);
        b_wd = upd_new;
        if (accept && s_tuser == OP_LOAD_B && in_b_ok) begin
            b_we = 1'b1;
            b_wa = OA_W'(in_oi);
            b_wd = in_val;
        end else if (s2_vld_reg && op_reg == OP_UPD && s2_bias_reg) begin
            b_we = 1'b1;
        end
    end

    assign wg_we   = s2_vld_reg && op_reg == OP_BWD;
    assign wg_wa   = waddr(32'(oi_reg), 32'(s2_j_reg));
    assign bg_we   = s2_vld_reg && op_reg == OP_BWD && s2_j_reg == '0;
    assign bg_wa   = OA_W'(oi_reg);
    assign x_we    = accept && s_tuser == OP_FWD && in_fwd_ok;
    assign x_wa    = xaddr(32'(in_smp), 32'(in_ii));
    assign facc_we = s2_vld_reg && op_reg == OP_FWD;
    assign facc_wa = OA_W'(s2_j_reg);
    assign bacc_we = s2_vld_reg && op_reg == OP_BWD && s2_in_use;
    assign bacc_wa = IA_W'(s2_j_reg);

    // Memories, with registered reads.
    logic [DW-1:0]     w_mem    [W_DEPTH];
    logic [GRAD_W-1:0] wg_mem   [W_DEPTH];
    logic [DW-1:0]     b_mem    [OUT_MAX];
    logic [GRAD_W-1:0] bg_mem   [OUT_MAX];
    logic [DW-1:0]     x_mem    [X_DEPTH];
    logic [ACC_W-1:0]  facc_mem [OUT_MAX];
    logic [ACC_W-1:0]  bacc_mem [IN_MAX];

    logic signed [DW-1:0]     w_rd_reg, b_rd_reg, x_rd_reg;
    logic signed [GRAD_W-1:0] wg_rd_reg, bg_rd_reg;
    logic signed [ACC_W-1:0]  facc_rd_reg, bacc_rd_reg;

    always_ff @(posedge aclk) begin
        if (w_we) w_mem[w_wa] <= w_wd;
        w_rd_reg <= w_mem[w_ra];
    end

    always_ff @(posedge aclk) begin
        if (wg_we) wg_mem[wg_wa] <= (s2_in_use ? grad_new : grad_old_reg);
        wg_rd_reg <= wg_mem[wg_ra];
    end

    always_ff @(posedge aclk) begin
        if (b_we) b_mem[b_wa] <= b_wd;
        b_rd_reg <= b_mem[b_ra];
    end

    always_ff @(posedge aclk) begin
        if (bg_we) bg_mem[bg_wa] <= bgrad_new;
        bg_rd_reg <= bg_mem[bg_ra];
    end

    always_ff @(posedge aclk) begin
        if (x_we) x_mem[x_wa] <= in_val;
        x_rd_reg <= x_mem[x_ra];
    end

    always_ff @(posedge aclk) begin
        if (facc_we) facc_mem[facc_wa] <= acc_new;
        facc_rd_reg <= facc_mem[facc_ra];
    end

    always_ff @(posedge aclk) begin
        if (bacc_we) bacc_mem[bacc_wa] <= acc_new;
        bacc_rd_reg <= bacc_mem[bacc_ra];
    end

    // Valid bits: a bias reads as zero until written, and a gradient row together
    // with its bias gradient reads as zero until a backward pass rewrites it.
    logic [OUT_MAX-1:0] b_vld_reg;
    logic [OUT_MAX-1:0] g_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg <= '0;
            g_vld_reg <= '0;
        end else begin
            if (b_we) b_vld_reg[b_wa] <= 1'b1;
            if (accept && (s_tuser == OP_CLR ||
                           (s_tuser == OP_BWD && in_bwd_ok && in_oi == '0 && in_smp == '0))) begin
                g_vld_reg <= '0;
            end else if (s2_vld_reg && op_reg == OP_BWD && 32'(s2_j_reg) == IN_MAX - 1) begin
                g_vld_reg[OA_W'(oi_reg)] <= 1'b1;
            end
        end
    end

    // Stage 1: memory data arrives, multiply.
    logic [CNT_W-1:0]         g_row;
    logic [CNT_W-1:0]         bias_o;
    logic signed [GRAD_W-1:0] grad_eff, bgrad_eff;
    logic signed [DW-1:0]     bias_eff;
    logic signed [MB_AW-1:0]  mb_a;
    logic signed [MB_BW-1:0]  mb_b;
    logic signed [ACC_W-1:0]  base;

    assign g_row     = (op_reg == OP_BWD) ? CNT_W'(oi_reg) : s1_o_reg;
    assign grad_eff  = g_vld_reg[OA_W'(g_row)] ? wg_rd_reg : '0;
    assign bgrad_eff = g_vld_reg[OA_W'(g_row)] ? bg_rd_reg : '0;
    assign bias_o    = (op_reg == OP_FWD) ? s1_j_reg : s1_o_reg;
    assign bias_eff  = b_vld_reg[OA_W'(bias_o)] ? b_rd_reg : '0;

    always_comb begin
        if (op_reg == OP_UPD) begin
            mb_a = $signed(MB_AW'(rate_reg));
            mb_b = s1_bias_reg ? MB_BW'(bgrad_eff) : MB_BW'(grad_eff);
        end else begin
            mb_a = MB_AW'(x_rd_reg);
            mb_b = MB_BW'(val_reg);
        end
        case (op_reg)
            OP_FWD:  base = (ii_reg == '0) ? (ACC_W'(bias_eff) <<< FRAC_BITS) : facc_rd_reg;
            OP_BWD:  base = (oi_reg == '0) ? '0 : bacc_rd_reg;
            default: base = s1_bias_reg ? ACC_W'(bias_eff) : ACC_W'(w_rd_reg);
        endcase
    end

    logic signed [2*DW-1:0]  prod_a_reg;
    logic signed [MB_PW-1:0] prod_b_reg;
    logic signed [ACC_W-1:0] acc_base_reg;

    always_ff @(posedge aclk) begin
        if (s1_vld_reg) begin
            prod_a_reg    <= w_rd_reg * val_reg;
            prod_b_reg    <= mb_a * mb_b;
            acc_base_reg  <= base;
            grad_old_reg  <= grad_eff;
            bgrad_old_reg <= bgrad_eff;
        end
        s1_j_reg    <= j_reg;
        s1_o_reg    <= k_reg;
        s1_bias_reg <= (state_reg == ST_UPD) && (j_reg == nin);
        s2_j_reg    <= s1_j_reg;
        s2_o_reg    <= s1_o_reg;
        s2_bias_reg <= s1_bias_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Stage 2: accumulate, round, saturate.
    logic signed [WIDE_W-1:0] pa, pb, wbase;
    logic signed [WIDE_W-1:0] acc_sum, g_term, g_sum, bg_sum, d_term, w_diff;

    always_comb begin
        pa      = WIDE_W'(prod_a_reg);
        pb      = WIDE_W'(prod_b_reg);
        wbase   = WIDE_W'(acc_base_reg);
        acc_sum = wbase + pa;
        acc_new = acc_sum[ACC_W-1:0];
        // Weight gradient term, rounded half up to the value scale.
        g_term  = (pb + HALF_F) >>> FRAC_BITS;
        g_sum   = WIDE_W'($signed(grad_old_reg)) + g_term;
        if (g_sum > G_MAX)      grad_new = G_MAX[GRAD_W-1:0];
        else if (g_sum < G_MIN) grad_new = G_MIN[GRAD_W-1:0];
        else                    grad_new = g_sum[GRAD_W-1:0];
        bg_sum  = WIDE_W'($signed(bgrad_old_reg)) + WIDE_W'(val_reg);
        if (bg_sum > G_MAX)      bgrad_new = G_MAX[GRAD_W-1:0];
        else if (bg_sum < G_MIN) bgrad_new = G_MIN[GRAD_W-1:0];
        else                     bgrad_new = bg_sum[GRAD_W-1:0];
        // Update step: old value minus rate times gradient.
        d_term  = (pb + HALF_R) >>> RATE_W;
        w_diff  = wbase - d_term;
        if (w_diff > D_MAX)      upd_new = D_MAX[DW-1:0];
        else if (w_diff < D_MIN) upd_new = D_MIN[DW-1:0];
        else                     upd_new = w_diff[DW-1:0];
    end

    // Emission: round and saturate an accumulator.
    logic signed [WIDE_W-1:0] em_wide;
    logic [DW-1:0]            em_val;
    logic                     em_sat;

    always_comb begin
        em_wide = (WIDE_W'((op_reg == OP_FWD) ? facc_rd_reg : bacc_rd_reg) + HALF_F)
                  >>> FRAC_BITS;
        em_sat  = 1'b1;
        if (em_wide > D_MAX) begin
            em_val = D_MAX[DW-1:0];
        end else if (em_wide < D_MIN) begin
            em_val = D_MIN[DW-1:0];
        end else begin
            em_val = em_wide[DW-1:0];
            em_sat = 1'b0;
        end
    end

    // Output register.
    logic [KIND_W-1:0] m_kind_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [SMP_W-1:0]  m_smp_reg;
    logic [DW-1:0]     m_val_reg;
    logic              m_last_reg;
    logic              m_sat_reg;
    logic              load_out;

    assign load_out = (state_reg == ST_EMIT_WR) || (state_reg == ST_RD_OUT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (load_out) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_EMIT_WR) begin
            m_kind_reg <= (op_reg == OP_FWD) ? KIND_FWD : KIND_DX;
            m_idx_reg  <= IDX_W'(j_reg);
            m_smp_reg  <= smp_reg;
            m_val_reg  <= em_val;
            m_last_reg <= (j_reg == emit_cnt - CNT_W'(1));
            m_sat_reg  <= em_sat;
        end else if (state_reg == ST_RD_OUT) begin
            m_smp_reg  <= '0;
            m_last_reg <= 1'b1;
            m_sat_reg  <= 1'b0;
            if (op_reg == OP_RD_W) begin
                m_kind_reg <= KIND_RD_W;
                m_idx_reg  <= ii_reg;
                m_val_reg  <= rd_w_ok ? w_rd_reg : '0;
            end else begin
                m_kind_reg <= KIND_RD_B;
                m_idx_reg  <= oi_reg;
                m_val_reg  <= (rd_b_ok && b_vld_reg[OA_W'(oi_reg)]) ? b_rd_reg : '0;
            end
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = {m_sat_reg, m_kind_reg};
    assign m_tlast  = m_last_reg;
    assign m_tdata  = M_TDATA_W'({m_val_reg, m_smp_reg, m_idx_reg});

endmodule
